FILE: src/gem_pkg.sv
// gem_pkg: shared constants and types for the 3x3 grayscale erosion block
// used by gem_front, gem_back and the top level under src; depends on nothing
package gem_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int PIX_W = 8;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  localparam int CFG_W_W    = 11;
  localparam int CFG_H_W    = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 4;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } border_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             res;
    border_t          border;
    logic             fe;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

endpackage

FILE: src/gem_fifo.sv
// gem_fifo: small register queue with occupancy count
// used for the command queue and the result queue; depends on nothing
module gem_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [DW-1:0]              wdata,
  input  logic                       pop,
  output logic [DW-1:0]              rdata,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_r [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign empty   = (cnt_r == NW'(0));
  assign full    = (cnt_r == NW'(DEPTH));
  assign count   = cnt_r;
  assign rdata   = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? AW'(0) : wptr_r + AW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? AW'(0) : rptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

FILE: src/gem_front.sv
// gem_front: input side of the erosion block; config registers, position counters,
// classification of each beat into ignore, pixel or flush; depends on gem_pkg
module gem_front import gem_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [CFG_IDX_W-1:0]                 cfg_index,
  input  logic [CFG_DATA_W-1:0]                cfg_data,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic [PIX_W-1:0]                     in_pixel_in,
  input  logic                                 in_drain,
  input  logic                                 cq_full,
  output logic                                 cq_push,
  output logic [$clog2(MAX_WIDTH)-1:0]         cq_addr,
  output cmd_t                                 cq_cmd
);

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int HW      = $clog2(MAX_HEIGHT + 1);
  localparam int RW      = $clog2(MAX_HEIGHT + 3);
  localparam int ROW_SAT = MAX_HEIGHT + 2;
  localparam int W_RST   = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int H_RST   = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

  logic [WW-1:0]      w_r, w_nxt;
  logic [HW-1:0]      h_r, h_nxt;
  logic [CW-1:0]      in_col_r, in_col_nxt;
  logic [RW-1:0]      in_row_r, in_row_nxt;
  logic [CW-1:0]      out_col_r, out_col_nxt;
  logic [RW-1:0]      out_row_r, out_row_nxt;
  logic [CFG_W_W-1:0] wv;
  logic [CFG_H_W-1:0] hv;
  logic               accept, flush, ignore, ready, wrap;
  logic [CW-1:0]      col;
  logic [CW:0]        col1, ocol1;
  logic [RW:0]        orow1;
  border_t            border;
  logic               fe;

  assign cfg_ready = 1'b1;
  assign in_full   = cq_full;
  assign accept    = in_push && !cq_full;

  assign wv = cfg_data[CFG_W_W-1:0];
  assign hv = cfg_data[CFG_H_W-1:0];

  always_comb begin
    w_nxt = w_r;
    h_nxt = h_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          if (wv == '0) w_nxt = WW'(1);
          else if (32'(wv) > MAX_WIDTH) w_nxt = WW'(MAX_WIDTH);
          else w_nxt = WW'(wv);
        end
        CFG_IMAGE_HEIGHT: begin
          if (hv == '0) h_nxt = HW'(1);
          else if (32'(hv) > MAX_HEIGHT) h_nxt = HW'(MAX_HEIGHT);
          else h_nxt = HW'(hv);
        end
        default: begin
        end
      endcase
    end
  end

  assign flush  = 32'(in_row_r) >= 32'(h_r);
  assign ignore = !flush && in_drain;
  assign col    = (32'(in_col_r) >= 32'(w_r)) ? CW'(0) : in_col_r;
  assign ready  = (in_row_r >= RW'(2)) || ((in_row_r == RW'(1)) && (col != CW'(0)));
  assign col1   = {1'b0, col} + (CW+1)'(1);
  assign wrap   = 32'(col1) >= 32'(w_r);

  assign ocol1         = {1'b0, out_col_r} + (CW+1)'(1);
  assign orow1         = {1'b0, out_row_r} + (RW+1)'(1);
  assign border.top    = out_row_r != RW'(0);
  assign border.bottom = 32'(orow1) < 32'(h_r);
  assign border.left   = out_col_r != CW'(0);
  assign border.right  = 32'(ocol1) < 32'(w_r);
  assign fe            = !border.bottom && !border.right;

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (accept && !ignore) begin
      if (wrap) begin
        in_col_nxt = CW'(0);
        in_row_nxt = (in_row_r == RW'(ROW_SAT)) ? in_row_r : in_row_r + RW'(1);
      end else begin
        in_col_nxt = col1[CW-1:0];
      end
      if (ready) begin
        if (fe) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (!border.right) begin
          out_col_nxt = CW'(0);
          out_row_nxt = orow1[RW-1:0];
        end else begin
          out_col_nxt = ocol1[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= WW'(W_RST);
      h_r       <= HW'(H_RST);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      w_r       <= w_nxt;
      h_r       <= h_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  assign cq_push       = accept && !ignore;
  assign cq_addr       = col;
  assign cq_cmd.pix    = flush ? PIX_MAX : in_pixel_in;
  assign cq_cmd.res    = ready;
  assign cq_cmd.border = border;
  assign cq_cmd.fe     = fe;

endmodule

FILE: src/gem_back.sv
// gem_back: execution side of the erosion block; line store memory, 3x3 window,
// bordered minimum and result-queue credit; depends on gem_pkg
module gem_back import gem_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cq_valid,
  input  logic [$clog2(MAX_WIDTH)-1:0]       cq_addr,
  input  cmd_t                               cq_cmd,
  output logic                               cq_pop,
  input  logic [$clog2(OUTQ_DEPTH+1)-1:0]    oq_count,
  output logic                               oq_push,
  output logic [PIX_W-1:0]                   oq_pix,
  output logic                               oq_fe
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int NW = $clog2(OUTQ_DEPTH + 1);

  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_r;
  logic [2*PIX_W-1:0] fwd_dat_r;
  logic               fwd_r;
  logic [2*PIX_W-1:0] eff, wdat;

  logic               s1_vld_r;
  logic [CW-1:0]      s1_addr_r;
  cmd_t               s1_cmd_r;
  logic               s2_res_r;
  border_t            s2_border_r;
  logic               s2_fe_r;

  logic [PIX_W-1:0]   win_r [9];
  logic [PIX_W-1:0]   win_nxt [9];
  logic [PIX_W-1:0]   m;
  logic [NW+1:0]      used;

  assign used   = (NW+2)'(oq_count) + (NW+2)'(s1_vld_r && s1_cmd_r.res) + (NW+2)'(s2_res_r);
  assign cq_pop = cq_valid && (used < (NW+2)'(OUTQ_DEPTH));

  // line store entry is {upper, middle}
  assign eff  = fwd_r ? fwd_dat_r : rd_r;
  assign wdat = {eff[PIX_W-1:0], s1_cmd_r.pix};

  always_ff @(posedge clk) begin
    if (cq_pop) begin
      rd_r <= mem[cq_addr];
    end
    if (s1_vld_r) begin
      mem[s1_addr_r] <= wdat;
    end
  end

  always_ff @(posedge clk) begin
    if (cq_pop) begin
      fwd_r     <= s1_vld_r && (s1_addr_r == cq_addr);
      fwd_dat_r <= wdat;
      s1_addr_r <= cq_addr;
      s1_cmd_r  <= cq_cmd;
    end
    if (s1_vld_r) begin
      s2_border_r <= s1_cmd_r.border;
      s2_fe_r     <= s1_cmd_r.fe;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3+0] = win_r[r*3+1];
      win_nxt[r*3+1] = win_r[r*3+2];
    end
    win_nxt[2] = eff[2*PIX_W-1:PIX_W];
    win_nxt[5] = eff[PIX_W-1:0];
    win_nxt[8] = s1_cmd_r.pix;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_res_r <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= '0;
      end
    end else begin
      s1_vld_r <= cq_pop;
      s2_res_r <= s1_vld_r && s1_cmd_r.res;
      if (s1_vld_r) begin
        for (int k = 0; k < 9; k++) begin
          win_r[k] <= win_nxt[k];
        end
      end
    end
  end

  always_comb begin
    m = win_r[4];
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!((r == 0 && !s2_border_r.top) || (r == 2 && !s2_border_r.bottom) ||
              (c == 0 && !s2_border_r.left) || (c == 2 && !s2_border_r.right))) begin
          if (win_r[r*3+c] < m) m = win_r[r*3+c];
        end
      end
    end
  end

  assign oq_push = s2_res_r;
  assign oq_pix  = m;
  assign oq_fe   = s2_fe_r;

endmodule

FILE: src/gray_erosion_3x3_min.sv
// gray_erosion_3x3_min: top level of the streaming 3x3 grayscale erosion block
// instantiates gem_front, gem_fifo and gem_back; depends on gem_pkg
//
// Takes one pixel beat per clock in raster order while in_full is low, and returns
// the minimum of the in-image 3x3 neighborhood of each position. Results trail the
// input by image_width+1 beats, so after the last pixel of a frame the user sends
// image_width+1 flush beats (drain beats, or pixels whose values are discarded) to
// flush the frame; the last result carries frame_end. A drain beat while pixels
// are still expected is taken and dropped. Sustained rate is one beat per clock
// on both sides while the result side is not stalled; a result reaches the out
// ports after passing a four-entry command queue, a line store read (one memory
// holding both previous rows, read then written back in the following cycle), a
// window stage and a four-entry result queue. in_full rises when the command queue
// is full, which happens only while the result side is stalled. Configuration
// writes are taken every clock, and are meant for idle periods between frames. No
// clearing pass after reset.
module gray_erosion_3x3_min import gem_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [PIX_W-1:0]      in_pixel_in,
  input  logic                  in_drain,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [PIX_W-1:0]      out_pixel_out,
  output logic                  out_frame_end
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CQW = CW + CMD_W;
  localparam int OQW = PIX_W + 1;

  logic                           cq_push, cq_pop, cq_full, cq_empty;
  logic [CW-1:0]                  cq_addr_in, cq_addr_out;
  cmd_t                           cq_cmd_in, cq_cmd_out;
  logic [CQW-1:0]                 cq_rdata;
  logic [$clog2(CMDQ_DEPTH+1)-1:0] cq_count;

  logic                           oq_push, oq_full, oq_fe;
  logic [PIX_W-1:0]               oq_pix;
  logic [OQW-1:0]                 oq_rdata;
  logic [$clog2(OUTQ_DEPTH+1)-1:0] oq_count;

  gem_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_pixel_in (in_pixel_in),
    .in_drain    (in_drain),
    .cq_full     (cq_full),
    .cq_push     (cq_push),
    .cq_addr     (cq_addr_in),
    .cq_cmd      (cq_cmd_in)
  );

  gem_fifo #(
    .DW    (CQW),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .wdata ({cq_addr_in, cq_cmd_in}),
    .pop   (cq_pop),
    .rdata (cq_rdata),
    .empty (cq_empty),
    .full  (cq_full),
    .count (cq_count)
  );

  assign cq_addr_out = cq_rdata[CQW-1:CMD_W];
  assign cq_cmd_out  = cq_rdata[CMD_W-1:0];

  gem_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_valid (!cq_empty),
    .cq_addr  (cq_addr_out),
    .cq_cmd   (cq_cmd_out),
    .cq_pop   (cq_pop),
    .oq_count (oq_count),
    .oq_push  (oq_push),
    .oq_pix   (oq_pix),
    .oq_fe    (oq_fe)
  );

  gem_fifo #(
    .DW    (OQW),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata ({oq_pix, oq_fe}),
    .pop   (out_pop),
    .rdata (oq_rdata),
    .empty (out_empty),
    .full  (oq_full),
    .count (oq_count)
  );

  assign out_pixel_out = oq_rdata[OQW-1:1];
  assign out_frame_end = oq_rdata[0];

  // result queue space is reserved before a beat enters the back end
  a_outq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(oq_push && oq_full))
    else $error("result queue overflow");

  a_cmdq_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cq_pop |-> !cq_empty)
    else $error("command queue popped while empty");

  a_cmdq_push_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
    cq_push |-> (in_push && !in_full))
    else $error("command pushed without an input beat");

  a_cmdq_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cq_full && !cq_pop) |=> (cq_count == $past(cq_count)))
    else $error("command queue lost entries");

endmodule
